FILE: rtl/stream_find_replace_core_assert.svh
// assertion macros used by the checker file of the find/replace core
// no dependencies; included by bare file name
`ifndef STREAM_FIND_REPLACE_CORE_ASSERT_SVH
`define STREAM_FIND_REPLACE_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define SFR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfr assertion failed");

// next-cycle implication, disabled while reset is high
`define SFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfr assertion failed");

`endif

FILE: rtl/sfr_pkg.sv
// types, constants and helpers for the stream find/replace core
// no dependencies; imported by every module of the core
`default_nettype none

package sfr_pkg;

   localparam int BYTE_W     = 8;
   localparam int CFG_W      = 64;
   localparam int CSR_ADDR_W = 5;

   // outcome of one compare of the candidate against the pattern
   typedef enum logic [1:0] {
      MATCH_NONE   = 2'd0,
      MATCH_PREFIX = 2'd1,
      MATCH_FULL   = 2'd2
   } match_type;

   typedef enum logic [1:0] {
      REG_PATTERN_BYTES      = 2'd0,
      REG_PATTERN_LENGTH     = 2'd1,
      REG_REPLACEMENT_BYTES  = 2'd2,
      REG_REPLACEMENT_LENGTH = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic              run_end;
      logic              text_end;
   } rsp_item_type;

   function automatic logic [BYTE_W-1:0] byte_of(input logic [CFG_W-1:0] word,
                                                 input logic [3:0] idx);
      byte_of = word[{idx[2:0], 3'b000} +: BYTE_W];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/sfr_match_unit.sv
// shared compare unit: candidate bytes against the pattern prefix
// depends on sfr_pkg
`default_nettype none

module sfr_match_unit
   import sfr_pkg::*;
#(
   parameter int PATTERN_MAX = 8
) (
   input  wire logic [PATTERN_MAX-1:0][BYTE_W-1:0]  cand,
   input  wire logic [$clog2(PATTERN_MAX+1)-1:0]    cand_len,
   input  wire logic [CFG_W-1:0]                    pattern_bytes,
   input  wire logic [$clog2(PATTERN_MAX+1)-1:0]    pattern_len,
   output match_type                                result
);

   logic [PATTERN_MAX-1:0] byte_ok;

   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         byte_ok[i] = (32'(cand_len) <= i) ||
                      (cand[i] == byte_of(pattern_bytes, 4'(i)));
      end
   end

   always_comb begin
      if (cand_len > pattern_len || !(&byte_ok)) begin
         result = MATCH_NONE;
      end else if (cand_len == pattern_len) begin
         result = MATCH_FULL;
      end else begin
         result = MATCH_PREFIX;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/sfr_out_stage.sv
// output register of the result channel, loads when empty or being drained
// depends on sfr_pkg
`default_nettype none

module sfr_out_stage
   import sfr_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   load,
   input  wire rsp_item_type load_item,
   output logic        free,
   output logic        rsp_valid,
   input  wire logic   rsp_ready,
   output rsp_item_type rsp_item
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = load_item;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

`default_nettype wire

FILE: rtl/stream_find_replace_core.sv
// channel | ports            | item contents
// req     | req_t*           | tdata: text_byte[7:0]; tlast: end_of_text
// rsp     | rsp_t*           | tdata: out_byte[7:0]; tlast: run_end;
//         |                  | tuser: byte_valid[0], text_end[1]
// csr     | csr_p*           | 64-bit registers at 0x00, 0x08, 0x10, 0x18
//
// an item passes through accept, check and finish; a failed check releases the oldest
// byte and rechecks the rest, a full match emits the replacement and a flush on the
// last byte emits the held bytes, one byte per cycle while the output register is
// free; there is a single compare unit.
// req_tready is high only while the sequencer is idle; a full output register
// stalls the sequencer. reset is synchronous and needs no clearing pass.
// top level of the stream find/replace core; depends on sfr_pkg, sfr_match_unit,
// sfr_out_stage
`default_nettype none

module stream_find_replace_core
   import sfr_pkg::*;
#(
   parameter int PATTERN_MAX     = 8,
   parameter int REPLACEMENT_MAX = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // text_byte[7:0]
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata,   // out_byte[7:0]
   output logic                       rsp_tlast,
   output logic [1:0]                 rsp_tuser,   // byte_valid[0], text_end[1]
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CFG_W-1:0]      csr_pwdata,
   output logic [CFG_W-1:0]           csr_prdata,
   output logic                       csr_pready
);

   localparam int CW = $clog2(PATTERN_MAX + 1);
   localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int RW = $clog2(REPLACEMENT_MAX + 2);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_REPL   = 5'b00100,
      ST_FLUSH  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   // configuration registers
   logic [CFG_W-1:0] pattern_bytes_ff, replacement_bytes_ff;
   logic [3:0]       pattern_length_ff, replacement_length_ff;
   logic             csr_write;
   reg_index_type    csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff      <= '0;
         pattern_length_ff     <= 4'd1;
         replacement_bytes_ff  <= '0;
         replacement_length_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_PATTERN_BYTES:      pattern_bytes_ff      <= csr_pwdata;
            REG_PATTERN_LENGTH:     pattern_length_ff     <= csr_pwdata[3:0];
            REG_REPLACEMENT_BYTES:  replacement_bytes_ff  <= csr_pwdata;
            REG_REPLACEMENT_LENGTH: replacement_length_ff <= csr_pwdata[3:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_PATTERN_BYTES:      csr_prdata = pattern_bytes_ff;
         REG_PATTERN_LENGTH:     csr_prdata = CFG_W'(pattern_length_ff);
         REG_REPLACEMENT_BYTES:  csr_prdata = replacement_bytes_ff;
         REG_REPLACEMENT_LENGTH: csr_prdata = CFG_W'(replacement_length_ff);
      endcase
   end

   // clamped lengths
   logic [CW-1:0] plen;
   logic [RW-1:0] rlen;

   assign plen = (pattern_length_ff == '0) ? CW'(1) :
                 (32'(pattern_length_ff) > PATTERN_MAX) ? CW'(PATTERN_MAX) :
                 CW'(pattern_length_ff);
   assign rlen = (32'(replacement_length_ff) > REPLACEMENT_MAX) ? RW'(REPLACEMENT_MAX) :
                 RW'(replacement_length_ff);

   // sequencer state
   state_type                         state_ff, state_in;
   logic [PATTERN_MAX-1:0][BYTE_W-1:0] cand_ff, cand_in;
   logic [CW-1:0]                     len_ff, len_in;
   logic                              eot_ff, eot_in;
   logic [RW-1:0]                     rep_idx_ff, rep_idx_in;
   logic                              pend_valid_ff, pend_valid_in;
   logic [BYTE_W-1:0]                 pend_byte_ff, pend_byte_in;

   match_type    match;
   logic         out_free;
   logic         push;
   rsp_item_type push_item;
   rsp_item_type rsp_item;
   logic         prod_req;
   logic [BYTE_W-1:0] prod_byte;
   logic         prod_ok;

   sfr_match_unit #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_match (
      .cand          (cand_ff),
      .cand_len      (len_ff),
      .pattern_bytes (pattern_bytes_ff),
      .pattern_len   (plen),
      .result        (match)
   );

   sfr_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (push),
      .load_item (push_item),
      .free      (out_free),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   assign rsp_tdata  = rsp_item.out_byte;
   assign rsp_tlast  = rsp_item.run_end;
   assign rsp_tuser  = {rsp_item.text_end, rsp_item.byte_valid};
   assign req_tready = (state_ff == ST_IDLE);

   // a produced byte waits in the pending slot so the last one can carry run_end
   assign prod_ok = !pend_valid_ff || out_free;

   always_comb begin
      state_in      = state_ff;
      cand_in       = cand_ff;
      len_in        = len_ff;
      eot_in        = eot_ff;
      rep_idx_in    = rep_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_byte_in  = pend_byte_ff;
      push          = 1'b0;
      push_item     = '0;
      prod_req      = 1'b0;
      prod_byte     = cand_ff[0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cand_in[len_ff[IW-1:0]] = req_tdata;
               len_in   = len_ff + CW'(1);
               eot_in   = req_tlast;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            case (match)
               MATCH_FULL: begin
                  len_in     = '0;
                  rep_idx_in = '0;
                  state_in   = ST_REPL;
               end
               MATCH_PREFIX: begin
                  state_in = eot_ff ? ST_FLUSH : ST_FINISH;
               end
               default: begin
                  // release the oldest byte and recheck the rest
                  prod_req = 1'b1;
                  if (prod_ok) begin
                     for (int i = 0; i < PATTERN_MAX - 1; i++) begin
                        cand_in[i] = cand_ff[i+1];
                     end
                     len_in = len_ff - CW'(1);
                     if (len_ff == CW'(1)) begin
                        state_in = ST_FINISH;
                     end
                  end
               end
            endcase
         end
         ST_REPL: begin
            if (rep_idx_ff == rlen) begin
               state_in = ST_FINISH;
            end else begin
               prod_req  = 1'b1;
               prod_byte = byte_of(replacement_bytes_ff, 4'(rep_idx_ff));
               if (prod_ok) begin
                  rep_idx_in = rep_idx_ff + RW'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (len_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               prod_req = 1'b1;
               if (prod_ok) begin
                  for (int i = 0; i < PATTERN_MAX - 1; i++) begin
                     cand_in[i] = cand_ff[i+1];
                  end
                  len_in = len_ff - CW'(1);
               end
            end
         end
         ST_FINISH: begin
            if (pend_valid_ff || eot_ff) begin
               if (out_free) begin
                  push                 = 1'b1;
                  push_item.out_byte   = pend_valid_ff ? pend_byte_ff : '0;
                  push_item.byte_valid = pend_valid_ff;
                  push_item.run_end    = 1'b1;
                  push_item.text_end   = eot_ff;
                  pend_valid_in        = 1'b0;
                  state_in             = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
      endcase

      if (prod_req && prod_ok) begin
         if (pend_valid_ff) begin
            push                 = 1'b1;
            push_item.out_byte   = pend_byte_ff;
            push_item.byte_valid = 1'b1;
            push_item.run_end    = 1'b0;
            push_item.text_end   = 1'b0;
         end
         pend_byte_in  = prod_byte;
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         len_ff        <= '0;
         eot_ff        <= 1'b0;
         rep_idx_ff    <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         eot_ff        <= eot_in;
         rep_idx_ff    <= rep_idx_in;
         pend_valid_ff <= pend_valid_in;
      end
      cand_ff      <= cand_in;
      pend_byte_ff <= pend_byte_in;
   end

endmodule

`default_nettype wire

FILE: rtl/stream_find_replace_core_checker.sv
// port-level checks of the stream find/replace core, bound to the top level
// depends on stream_find_replace_core_assert.svh
`default_nettype none

`include "stream_find_replace_core_assert.svh"

module stream_find_replace_core_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic       rsp_tlast,
   input wire logic [1:0] rsp_tuser
);

   // a stalled result item holds
   `SFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))

   // a bare end marker is zero and closes both run and text
   `SFR_ASSERT_NOW(a_empty_marker, clock, reset, rsp_tvalid && !rsp_tuser[0], rsp_tdata == 8'd0 && rsp_tlast && rsp_tuser[1])

   // the end of the text is always the end of a run
   `SFR_ASSERT_NOW(a_text_end_last, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tlast)

   // the sequencer is busy in the cycle after taking an item
   `SFR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule

bind stream_find_replace_core stream_find_replace_core_checker u_checker (.*);

`default_nettype wire
